// ===== rtl/core/column_geometric_features_assert.svh =====
// Assertion shorthands for the column feature block.
// Both sample on clock and are switched off while reset is high.
`ifndef COLUMN_GEOMETRIC_FEATURES_ASSERT_SVH
`define COLUMN_GEOMETRIC_FEATURES_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CGF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("column feature check failed");

// Consequent checked in the cycle after the antecedent.
`define CGF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("column feature check failed");

`endif

// ===== rtl/core/cgf_pkg.sv =====
package cgf_pkg;

   localparam int DEF_MAX_HEIGHT = 64;
   localparam int COL_W          = 64;
   localparam int SEG_ROWS       = 8;
   localparam int ROW_W          = 7;
   localparam int FRAC_BITS      = 10;

   localparam int LANE_CNT_W     = 4;
   localparam int LANE_S1_W      = 9;
   localparam int LANE_S2_W      = 15;
   localparam int LANE_TR_W      = 4;

   localparam int CNT_W          = 7;
   localparam int S1_W           = 12;
   localparam int S2_W           = 17;
   localparam int TR_W           = 6;
   localparam int INNER_W        = 6;
   localparam int MEAN_W         = 16;
   localparam int MOM_W          = 15;
   localparam int SLOPE_W        = 8;

   localparam int DIVIDEND_W     = S2_W + FRAC_BITS;
   localparam int DIVISOR_W      = 13;
   localparam int QUO_W          = 16;
   localparam int REM_W          = DIVISOR_W + 1;

   typedef struct packed {
      logic                  any;
      logic [ROW_W-1:0]      first_row;
      logic [ROW_W-1:0]      last_row;
      logic [LANE_CNT_W-1:0] count;
      logic [LANE_S1_W-1:0]  s1;
      logic [LANE_S2_W-1:0]  s2;
      logic [LANE_TR_W-1:0]  trans;
   } lane_sum_type;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [S1_W-1:0]    s1;
      logic [S2_W-1:0]    s2;
      logic [ROW_W-1:0]   top;
      logic [ROW_W-1:0]   bottom;
      logic [TR_W-1:0]    trans;
      logic [INNER_W-1:0] inner;
   } merge_type;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [MEAN_W-1:0]  mean;
      logic [MOM_W-1:0]   mom;
      logic [ROW_W-1:0]   top;
      logic [ROW_W-1:0]   bottom;
      logic [TR_W-1:0]    trans;
      logic [INNER_W-1:0] inner;
   } feat_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   // Clamp the height register to 1..hmax.
   function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h,
                                                   input logic [ROW_W-1:0] hmax);
      logic [ROW_W-1:0] r;
      r = h;
      if (h == '0) begin
         r = ROW_W'(1);
      end else if (h > hmax) begin
         r = hmax;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/cgf_lane.sv =====
module cgf_lane #(
   parameter int LANE_INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic [cgf_pkg::SEG_ROWS-1:0]         seg_bits,
   input  logic [cgf_pkg::SEG_ROWS-1:0]         seg_valid,
   input  logic                                 prev_bit,
   output cgf_pkg::lane_sum_type                lane_sum
);
   import cgf_pkg::*;

   lane_sum_type          sum_in;
   lane_sum_type          sum_ff;
   logic [SEG_ROWS:0]     window;
   logic [ROW_W-1:0]      row;

   assign window = {seg_bits, prev_bit};

   always_comb begin
      sum_in = '0;
      row    = '0;
      for (int i = 0; i < SEG_ROWS; i++) begin
         row = ROW_W'(LANE_INDEX * SEG_ROWS + i + 1);
         if (seg_bits[i]) begin
            sum_in.count = sum_in.count + LANE_CNT_W'(1);
            sum_in.s1    = sum_in.s1 + LANE_S1_W'(row);
            sum_in.s2    = sum_in.s2 + LANE_S2_W'((LANE_INDEX * SEG_ROWS + i + 1) *
                                                  (LANE_INDEX * SEG_ROWS + i + 1));
            if (!sum_in.any) begin
               sum_in.first_row = row;
            end
            sum_in.any      = 1'b1;
            sum_in.last_row = row;
         end
         // row 1 has no row above it
         if (seg_valid[i] && (window[i+1] != window[i]) &&
             ((i > 0) || (LANE_INDEX > 0))) begin
            sum_in.trans = sum_in.trans + LANE_TR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

   assign lane_sum = sum_ff;

endmodule

// ===== rtl/core/cgf_merge.sv =====
module cgf_merge #(
   parameter int LANES = 8
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [cgf_pkg::ROW_W-1:0]     height,
   input  cgf_pkg::lane_sum_type         lane_sums [LANES],
   output cgf_pkg::merge_type            merged
);
   import cgf_pkg::*;

   merge_type merge_in;
   merge_type merge_ff;

   always_comb begin
      merge_in        = '0;
      merge_in.top    = height + ROW_W'(1);
      merge_in.bottom = '0;
      for (int l = 0; l < LANES; l++) begin
         merge_in.count = merge_in.count + CNT_W'(lane_sums[l].count);
         merge_in.s1    = merge_in.s1 + S1_W'(lane_sums[l].s1);
         merge_in.s2    = merge_in.s2 + S2_W'(lane_sums[l].s2);
         merge_in.trans = merge_in.trans + TR_W'(lane_sums[l].trans);
         if (lane_sums[l].any) begin
            merge_in.bottom = lane_sums[l].last_row;
         end
         if (lane_sums[LANES-1-l].any) begin
            merge_in.top = lane_sums[LANES-1-l].first_row;
         end
      end
      if (merge_in.count >= CNT_W'(2)) begin
         merge_in.inner = INNER_W'(merge_in.count - CNT_W'(2));
      end else begin
         merge_in.inner = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         merge_ff <= merge_in;
      end
   end

   assign merged = merge_ff;

endmodule

// ===== rtl/core/cgf_divider.sv =====
module cgf_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cgf_pkg::div_req_type  div_req,
   output cgf_pkg::div_rsp_type  div_rsp
);
   import cgf_pkg::*;

   localparam int STEPS = 2;
   localparam int ITER  = QUO_W / STEPS;
   localparam int ITER_W = $clog2(ITER);

   logic                 busy_ff;
   logic                 done_ff;
   logic [ITER_W-1:0]    iter_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] dsr_ff;

   logic [REM_W-1:0]     rem_in;
   logic [QUO_W-1:0]     quo_in;
   logic [REM_W-1:0]     trial;

   // two restoring steps per cycle; remainder stays below the divisor
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int s = 0; s < STEPS; s++) begin
         trial = {rem_in[REM_W-2:0], quo_in[QUO_W-1]};
         if (trial >= REM_W'(dsr_ff)) begin
            rem_in = trial - REM_W'(dsr_ff);
            quo_in = {quo_in[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_in[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_W'(ITER - 1);
            // quotient fits QUO_W bits, so the upper dividend is below the divisor
            rem_ff  <= REM_W'(div_req.dividend >> QUO_W);
            quo_ff  <= div_req.dividend[QUO_W-1:0];
            dsr_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            iter_ff <= iter_ff - ITER_W'(1);
            if (iter_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/column_geometric_features.sv =====
// Channel  Direction  Handshake             Carries
// req_     in         req_valid/req_stall   one column bitmap, last-column flag
// rsp_     out        rsp_valid/rsp_stall   seven features, two slopes, last flag
// csr_     in         csr_wr_en             height register, no read-back
//
// A column passes from acceptance to the next acceptance through lanes,
// merge and divider launch, then two divisions, each with its done step, on
// the shared radix-4 divider, and then, where a result is due, its
// emission; a last column with a pending one emits both results.
// Reset (synchronous, active high) clears the sequencer, the pending column
// and the height to 64. A stalled result holds in the output register; the
// block still takes the next column, and only waits at emission time.
module column_geometric_features #(
   parameter int MAX_HEIGHT = cgf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_wr_en,
   input  logic [6:0]          csr_wr_data,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [63:0]         req_column_bits,
   input  logic                req_last_column,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [6:0]          rsp_black_count,
   output logic [15:0]         rsp_mean_row_q10,
   output logic [14:0]         rsp_moment_q10,
   output logic [6:0]          rsp_top_row,
   output logic [6:0]          rsp_bottom_row,
   output logic signed [7:0]   rsp_top_slope_x2,
   output logic signed [7:0]   rsp_bottom_slope_x2,
   output logic [5:0]          rsp_transitions,
   output logic [5:0]          rsp_inner_black,
   output logic                rsp_last_result
);
   import cgf_pkg::*;

   localparam int LANES = (MAX_HEIGHT + SEG_ROWS - 1) / SEG_ROWS;
   localparam logic [ROW_W-1:0] HMAX = ROW_W'(MAX_HEIGHT);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LANE,
      ST_MERGE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_MOM_WAIT,
      ST_EMIT_PEND,
      ST_EMIT_LAST
   } state_type;

   state_type            state_ff;

   // configuration and image context
   logic [ROW_W-1:0]     height_ff;
   logic                 pend_valid_ff;
   feat_type             pend_ff;
   logic [ROW_W-1:0]     prev_top_ff;
   logic [ROW_W-1:0]     prev_bot_ff;

   // column in flight
   logic [COL_W-1:0]     col_ff;
   logic [COL_W-1:0]     rowv_ff;
   logic                 last_ff;
   logic [ROW_W-1:0]     h_ff;
   logic [DIVISOR_W-1:0] hsq_ff;
   feat_type             cur_ff;
   feat_type             cur_done;

   // output register
   logic                 rsp_valid_ff;
   feat_type             out_feat_ff;
   logic [SLOPE_W-1:0]   out_top_slope_ff;
   logic [SLOPE_W-1:0]   out_bot_slope_ff;
   logic                 out_last_ff;

   logic [ROW_W-1:0]     h_eff;
   logic [COL_W-1:0]     row_mask;
   logic                 out_free;

   lane_sum_type         lane_sums [LANES];
   merge_type            merged;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign h_eff    = eff_height(height_ff, HMAX);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // bit positions at or above the height (rows past the height) are masked off
   always_comb begin
      for (int k = 0; k < COL_W; k++) begin
         row_mask[k] = (ROW_W'(k) < h_eff);
      end
   end

   // lanes: each one scans SEG_ROWS rows of the column
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic prev_bit;
      if (g == 0) begin : g_first
         assign prev_bit = 1'b0;
      end else begin : g_rest
         assign prev_bit = col_ff[g*SEG_ROWS-1];
      end
      cgf_lane #(
         .LANE_INDEX (g)
      ) u_lane (
         .clock     (clock),
         .load      (state_ff == ST_LANE),
         .seg_bits  (col_ff[g*SEG_ROWS +: SEG_ROWS]),
         .seg_valid (rowv_ff[g*SEG_ROWS +: SEG_ROWS]),
         .prev_bit  (prev_bit),
         .lane_sum  (lane_sums[g])
      );
   end

   cgf_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .load      (state_ff == ST_MERGE),
      .height    (h_ff),
      .lane_sums (lane_sums),
      .merged    (merged)
   );

   // mean launches after merge; the moment launches as the mean completes
   always_comb begin
      div_req = '0;
      if (state_ff == ST_MEAN_GO) begin
         div_req.start    = 1'b1;
         div_req.dividend = DIVIDEND_W'({merged.s1, FRAC_BITS'(0)});
         div_req.divisor  = DIVISOR_W'(h_ff);
      end else if ((state_ff == ST_MEAN_WAIT) && div_rsp.done) begin
         div_req.start    = 1'b1;
         div_req.dividend = {merged.s2, FRAC_BITS'(0)};
         div_req.divisor  = hsq_ff;
      end
   end

   cgf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      cur_done     = cur_ff;
      cur_done.mom = div_rsp.quotient[MOM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         height_ff     <= ROW_W'(64);
         pend_valid_ff <= 1'b0;
         prev_top_ff   <= eff_height(ROW_W'(64), HMAX) + ROW_W'(1);
         prev_bot_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // with nothing pending the first column's previous top follows height
         if (csr_wr_en) begin
            height_ff <= csr_wr_data;
            if (!pend_valid_ff) begin
               prev_top_ff <= eff_height(csr_wr_data, HMAX) + ROW_W'(1);
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  col_ff   <= req_column_bits & row_mask;
                  rowv_ff  <= row_mask;
                  last_ff  <= req_last_column;
                  h_ff     <= h_eff;
                  state_ff <= ST_LANE;
               end
            end
            ST_LANE: begin
               hsq_ff   <= DIVISOR_W'(h_ff) * DIVISOR_W'(h_ff);
               state_ff <= ST_MERGE;
            end
            ST_MERGE: begin
               state_ff <= ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
               cur_ff.count  <= merged.count;
               cur_ff.top    <= merged.top;
               cur_ff.bottom <= merged.bottom;
               cur_ff.trans  <= merged.trans;
               cur_ff.inner  <= merged.inner;
               state_ff      <= ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
               if (div_rsp.done) begin
                  cur_ff.mean <= div_rsp.quotient;
                  state_ff    <= ST_MOM_WAIT;
               end
            end
            ST_MOM_WAIT: begin
               if (div_rsp.done) begin
                  cur_ff <= cur_done;
                  if (pend_valid_ff) begin
                     state_ff <= ST_EMIT_PEND;
                  end else if (last_ff) begin
                     state_ff <= ST_EMIT_LAST;
                  end else begin
                     pend_ff       <= cur_done;
                     pend_valid_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end
               end
            end
            ST_EMIT_PEND: begin
               // pending column: slopes from the current column and the one before the pending one
               if (out_free) begin
                  rsp_valid_ff     <= 1'b1;
                  out_feat_ff      <= pend_ff;
                  out_top_slope_ff <= SLOPE_W'(cur_ff.top) - SLOPE_W'(prev_top_ff);
                  out_bot_slope_ff <= SLOPE_W'(cur_ff.bottom) - SLOPE_W'(prev_bot_ff);
                  out_last_ff      <= 1'b0;
                  prev_top_ff      <= pend_ff.top;
                  prev_bot_ff      <= pend_ff.bottom;
                  if (last_ff) begin
                     state_ff <= ST_EMIT_LAST;
                  end else begin
                     pend_ff  <= cur_ff;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_EMIT_LAST: begin
               // final column: next extremes are those of an empty column
               if (out_free) begin
                  rsp_valid_ff     <= 1'b1;
                  out_feat_ff      <= cur_ff;
                  out_top_slope_ff <= SLOPE_W'(h_ff) + SLOPE_W'(1) - SLOPE_W'(prev_top_ff);
                  out_bot_slope_ff <= SLOPE_W'(0) - SLOPE_W'(prev_bot_ff);
                  out_last_ff      <= 1'b1;
                  pend_valid_ff    <= 1'b0;
                  prev_top_ff      <= h_ff + ROW_W'(1);
                  prev_bot_ff      <= '0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_black_count     = out_feat_ff.count;
   assign rsp_mean_row_q10    = out_feat_ff.mean;
   assign rsp_moment_q10      = out_feat_ff.mom;
   assign rsp_top_row         = out_feat_ff.top;
   assign rsp_bottom_row      = out_feat_ff.bottom;
   assign rsp_top_slope_x2    = $signed(out_top_slope_ff);
   assign rsp_bottom_slope_x2 = $signed(out_bot_slope_ff);
   assign rsp_transitions     = out_feat_ff.trans;
   assign rsp_inner_black     = out_feat_ff.inner;
   assign rsp_last_result     = out_last_ff;

endmodule

// ===== rtl/core/cgf_checker.sv =====
`include "column_geometric_features_assert.svh"

module cgf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [6:0]         rsp_black_count,
   input logic [15:0]        rsp_mean_row_q10,
   input logic [14:0]        rsp_moment_q10,
   input logic [6:0]         rsp_top_row,
   input logic [6:0]         rsp_bottom_row,
   input logic signed [7:0]  rsp_top_slope_x2,
   input logic signed [7:0]  rsp_bottom_slope_x2,
   input logic [5:0]         rsp_transitions,
   input logic [5:0]         rsp_inner_black,
   input logic               rsp_last_result
);

   // stalled result transaction keeps its payload
   `CGF_ASSERT_SAME(a_rsp_hold, $past(rsp_valid && rsp_stall), rsp_valid && $stable(rsp_black_count) && $stable(rsp_mean_row_q10) && $stable(rsp_moment_q10) && $stable(rsp_top_row) && $stable(rsp_bottom_row) && $stable(rsp_top_slope_x2) && $stable(rsp_bottom_slope_x2) && $stable(rsp_transitions) && $stable(rsp_inner_black) && $stable(rsp_last_result))

   // one column in work at a time
   `CGF_ASSERT_NEXT(a_one_column, req_valid && !req_stall, req_stall)

   // no result appears as a taken column moves from acceptance into the lane stage
   `CGF_ASSERT_NEXT(a_no_early_result, req_valid && !req_stall, !$rose(rsp_valid))

   // nothing is offered right after reset
   `CGF_ASSERT_SAME(a_quiet_after_reset, $past(reset), !rsp_valid)

endmodule

bind column_geometric_features cgf_checker u_cgf_checker (.*);
